[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the deque checker.
// They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication, checked outside reset
`define BDQ_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BDQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, constants and pointer helpers for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic    wr_front;
        logic    wr_back;
        logic    rd_front;
        logic    rd_back;
        logic    rd_first;
        logic    rd_next;
        logic    out_load;
        logic    out_ram;
        status_t out_status;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic dump_last;
        logic out_free;
    } stat_t;

    localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(DEPTH);
    localparam ptr_t PTR_MAX = PTR_W'(DEPTH - 1);

    // Slot at a given offset from base, wrapped once
    function automatic ptr_t slot_of(input ptr_t base, input ptr_t off);
        logic [PTR_W:0] sum;
        logic [PTR_W:0] wrapped;
        sum = {1'b0, base} + {1'b0, off};
        wrapped = (sum >= DEPTH_EXT) ? (sum - DEPTH_EXT) : sum;
        return wrapped[PTR_W-1:0];
    endfunction

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_MAX) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        return (p == '0) ? PTR_MAX : p - PTR_W'(1);
    endfunction

endpackage

[rtl/core/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/bdq_datapath.sv]
// ----------------------------------------------------------------------------
// bdq_datapath
// Front pointer, entry count, dump index, entry RAM and result register.
// ----------------------------------------------------------------------------
module bdq_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bdq_pkg::cmd_t          cmd,
    output bdq_pkg::stat_t         stat,
    input  logic signed [31:0]     value,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic signed [31:0]     result_value,
    output logic [1:0]             status,
    output logic                   last
);

    import bdq_pkg::*;

    ptr_t    front_reg;
    ptr_t    front_next;
    cnt_t    count_reg;
    cnt_t    count_next;
    ptr_t    idx_reg;
    ptr_t    idx_next;
    cnt_t    count_dec;
    ptr_t    front_dec;

    logic              wr_en;
    ptr_t              wr_addr;
    logic              rd_en;
    ptr_t              rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    assign count_dec = count_reg - CNT_W'(1);
    assign front_dec = ptr_dec(front_reg);

    always_comb
    begin
        wr_en   = cmd.wr_front | cmd.wr_back;
        wr_addr = cmd.wr_front ? front_dec : slot_of(front_reg, count_reg[PTR_W-1:0]);
        rd_en   = cmd.rd_front | cmd.rd_back | cmd.rd_first | cmd.rd_next;
        priority if (cmd.rd_back)
        begin
            rd_addr = slot_of(front_reg, count_dec[PTR_W-1:0]);
        end
        else if (cmd.rd_next)
        begin
            rd_addr = slot_of(front_reg, idx_reg + PTR_W'(1));
        end
        else
        begin
            rd_addr = front_reg;
        end
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.wr_front)
        begin
            front_next = front_dec;
        end
        if (cmd.rd_front)
        begin
            front_next = ptr_inc(front_reg);
        end
        if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.rd_front | cmd.rd_back)
        begin
            count_next = count_dec;
        end
        if (cmd.rd_first)
        begin
            idx_next = '0;
        end
        if (cmd.rd_next)
        begin
            idx_next = idx_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word: load only when the slot is free
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg  <= cmd.out_ram ? rd_data : '0;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

endmodule

[rtl/core/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request decoder and sequencer for pops and dumps.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  logic [2:0]     op,
    input  bdq_pkg::stat_t stat,
    output bdq_pkg::cmd_t  cmd
);

    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = (state_reg == S_IDLE) && req_valid && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !stat.empty)
                begin
                    if (op == OP_POP_FRONT || op == OP_POP_BACK)
                    begin
                        state_next = S_READ;
                    end
                    else if (op == OP_DUMP)
                    begin
                        state_next = S_DUMP;
                    end
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (stat.out_free && stat.dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.out_status = ST_OK;
        req_stall      = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = !stat.out_free;
                if (accept)
                begin
                    unique case (op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.full)
                            begin
                                cmd.out_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_front = (op == OP_PUSH_FRONT);
                                cmd.wr_back  = (op == OP_PUSH_BACK);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_front = (op == OP_POP_FRONT);
                                cmd.rd_back  = (op == OP_POP_BACK);
                                cmd.rd_first = (op == OP_DUMP);
                            end
                        end
                        default:
                        begin
                            // drop unused codes
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_ram  = 1'b1;
                    cmd.out_last = 1'b1;
                end
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_ram  = 1'b1;
                    cmd.out_last = stat.dump_last;
                    cmd.rd_next  = !stat.dump_last;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/bounded_deque.sv]
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit words in a circular RAM of DEPTH
// entries. A push at either end answers with one word (status full if the
// store is full). A pop reads the entry RAM through its registered read
// port and answers with the removed word. A dump answers with one word per
// stored entry, walking the RAM from front to back and marking the final
// word with last; a pop or dump of an empty store answers at once with
// status empty. Each result word waits in an output register, so a push
// may be taken while the previous result is still held; a stalled result
// holds the whole block. No clearing pass follows reset: the block is
// ready as soon as reset is released.
// ----------------------------------------------------------------------------
module bounded_deque (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] result_value,
    output logic [1:0]         status,
    output logic               last
);

    import bdq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .stat      (stat),
        .cmd       (cmd)
    );

    bdq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .value        (value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_value (result_value),
        .status       (status),
        .last         (last)
    );

endmodule

[rtl/core/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic [2:0]         op,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic signed [31:0] result_value,
    input logic [1:0]         status,
    input logic               last
);

    import bdq_pkg::*;

    `BDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(result_value) && $stable(status) && $stable(last), "stalled result word changed")

    `BDQ_ASSERT_IMPL(a_reject_word, rsp_valid && (status != ST_OK), (result_value == 0) && last, "empty or full word must be zero and last")

    `BDQ_ASSERT_IMPL(a_dump_blocks, rsp_valid && !last, req_stall, "request taken during a dump")

    `BDQ_ASSERT_NEXT(a_push_answer, req_valid && !req_stall && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK), rsp_valid && last, "push gave no single result word")

endmodule

bind bounded_deque bdq_checker u_checker (.*);

[dv/bounded_deque_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_tb
// Self-checking bench for the bounded deque. A short table of directed
// requests covers the empty, full and extreme cases and the spare op codes;
// randomised bursts then sweep the store between empty and full under
// several idling and stall mixes, with one long output hold-off. Every
// accepted request is run through a behavioural copy of the deque; each result
// word is compared field by field, in order, with the pinned or predicted word.
// ----------------------------------------------------------------------------
module bounded_deque_tb;

    import bdq_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 2 * DEPTH + 8;
    localparam int PRINT_LIMIT     = 40;

    typedef struct packed {
        logic [31:0] word;
        status_t     code;
        logic        fin;
    } deque_word_t;

    typedef struct packed {
        logic [2:0]  code;
        logic [31:0] arg;
        logic        pin;
        deque_word_t want;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [2:0]         op = OP_PUSH_FRONT;
    logic signed [31:0] value = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               last;

    logic               row_pinned = 1'b0;
    deque_word_t        row_want = '0;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_off_left = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    logic [31:0] slots [DEPTH];
    int          front_slot = 0;
    int          fill_level = 0;
    deque_word_t expected_words[$];

    bounded_deque dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .op           (op),
        .value        (value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_value (result_value),
        .status       (status),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
    endtask

    task automatic predict_deque(input logic [2:0] code, input logic [31:0] arg,
                                 ref deque_word_t due[$]);
        int i;
        case (code)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill_level == DEPTH)
                    due.push_back('{32'd0, ST_FULL, 1'b1});
                else
                begin
                    if (code == OP_PUSH_FRONT)
                    begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        slots[front_slot] = arg;
                    end
                    else
                        slots[(front_slot + fill_level) % DEPTH] = arg;
                    fill_level++;
                    due.push_back('{32'd0, ST_OK, 1'b1});
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill_level == 0)
                    due.push_back('{32'd0, ST_EMPTY, 1'b1});
                else
                begin
                    if (code == OP_POP_FRONT)
                    begin
                        due.push_back('{slots[front_slot], ST_OK, 1'b1});
                        front_slot = (front_slot + 1) % DEPTH;
                    end
                    else
                        due.push_back('{slots[(front_slot + fill_level - 1) % DEPTH],
                                        ST_OK, 1'b1});
                    fill_level--;
                end
            end
            OP_DUMP:
            begin
                if (fill_level == 0)
                    due.push_back('{32'd0, ST_EMPTY, 1'b1});
                else
                    for (i = 0; i < fill_level; i++)
                        due.push_back('{slots[(front_slot + i) % DEPTH], ST_OK,
                                        logic'(i == fill_level - 1)});
            end
            default:
            begin
            end
        endcase
    endtask

    // check result words, then log the request taken at this edge
    always @(posedge clk)
    begin
        deque_word_t want;
        deque_word_t due[$];
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", result_value, 32'd0);
                else
                begin
                    want = expected_words.pop_front();
                    if (result_value !== want.word)
                        report_mismatch("result_value", result_value, want.word);
                    if (status !== want.code)
                        report_mismatch("status", 32'(status), 32'(want.code));
                    if (last !== want.fin)
                        report_mismatch("last", 32'(last), 32'(want.fin));
                end
            end
            if (req_valid && !req_stall)
            begin
                due.delete();
                predict_deque(op, value, due);
                if (row_pinned)
                    expected_words.push_back(row_want);
                else
                    foreach (due[i])
                        expected_words.push_back(due[i]);
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: long hold-off when asked, random stalls otherwise
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_off_left--;
            end
            else
                rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    task automatic send_word(input logic [2:0] code, input logic [31:0] arg,
                             input logic pin, input deque_word_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        op         <= code;
        value      <= arg;
        row_pinned <= pin;
        row_want   <= want;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // push bias drifts between filling and draining unless pinned by fill_bias
    task automatic random_burst(input int words, input int fill_bias);
        int         bias;
        int         run;
        int         r;
        logic [2:0] code;
        bias = 50;
        run = 0;
        repeat (words)
        begin
            if (run == 0)
            begin
                run = $urandom_range(20, 6);
                case ($urandom_range(2))
                    0: bias = 85;
                    1: bias = 15;
                    default: bias = 50;
                endcase
            end
            run--;
            if (fill_bias >= 0)
                bias = fill_bias;
            r = $urandom_range(99);
            if (r < 3)
            begin
                case ($urandom_range(2))
                    0: code = OP_SPARE_A;
                    1: code = OP_SPARE_B;
                    default: code = OP_SPARE_C;
                endcase
            end
            else if (r < 12)
                code = OP_DUMP;
            else if ($urandom_range(99) < bias)
                code = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                code = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            send_word(code, pick_value(), 1'b0, '0);
        end
    endtask

    initial
    begin
        plan_row_t   plan[$];
        logic [31:0] fill_word;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back('{OP_POP_FRONT, 32'd0, 1'b1, '{32'd0, ST_EMPTY, 1'b1}});
        plan.push_back('{OP_POP_BACK, 32'hFFFF_FFFF, 1'b1, '{32'd0, ST_EMPTY, 1'b1}});
        plan.push_back('{OP_DUMP, 32'd0, 1'b1, '{32'd0, ST_EMPTY, 1'b1}});
        plan.push_back('{OP_SPARE_A, 32'h1234_5678, 1'b0, '0});
        plan.push_back('{OP_SPARE_B, 32'd0, 1'b0, '0});
        plan.push_back('{OP_SPARE_C, 32'hFFFF_FFFF, 1'b0, '0});
        plan.push_back('{OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b1, '{32'd0, ST_OK, 1'b1}});
        plan.push_back('{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'd0, ST_OK, 1'b1}});
        plan.push_back('{OP_DUMP, 32'd0, 1'b0, '0});
        fill_word = '0;
        for (int i = 0; i < DEPTH - 2; i++)
        begin
            fill_word = 32'hA5A5_0000 ^ (32'(i) * 32'h0101_0101);
            plan.push_back('{OP_PUSH_BACK, fill_word, 1'b1, '{32'd0, ST_OK, 1'b1}});
        end
        plan.push_back('{OP_PUSH_FRONT, 32'h5555_5555, 1'b1, '{32'd0, ST_FULL, 1'b1}});
        plan.push_back('{OP_PUSH_BACK, 32'hAAAA_AAAA, 1'b1, '{32'd0, ST_FULL, 1'b1}});
        plan.push_back('{OP_DUMP, 32'd0, 1'b0, '0});
        plan.push_back('{OP_POP_FRONT, 32'd0, 1'b1, '{32'h8000_0000, ST_OK, 1'b1}});
        plan.push_back('{OP_POP_BACK, 32'd0, 1'b1, '{fill_word, ST_OK, 1'b1}});

        foreach (plan[i])
            send_word(plan[i].code, plan[i].arg, plan[i].pin, plan[i].want);

        random_burst(65, -1);
        send_idle_pct = 65;
        random_burst(65, -1);
        send_idle_pct = 0;
        rsp_stall_pct = 65;
        random_burst(65, -1);
        send_idle_pct = 20;
        rsp_stall_pct = 20;
        random_burst(65, -1);

        // hold the output back while pushes keep coming
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_off_left = HOLD_OFF_CYCLES;
        random_burst(30, 90);

        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch("words outstanding", 32'(expected_words.size()), 32'd0);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
